// File: rtl/vau_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vau_pkg: shared types of the vector arithmetic unit
// Command codes and the control group that travels from the top level into
// the product lanes and the merging stage.
// ----------------------------------------------------------------------------
package vau_pkg;

    typedef enum logic [3:0] {
        CMD_ADD   = 4'd0,
        CMD_SUB   = 4'd1,
        CMD_MUL   = 4'd2,
        CMD_DIV   = 4'd3,
        CMD_DOT   = 4'd4,
        CMD_CROSS = 4'd5,
        CMD_SQLEN = 4'd6,
        CMD_LEN   = 4'd7,
        CMD_NORM  = 4'd8,
        CMD_NEG   = 4'd9
    } cmd_t;

    typedef struct packed {
        logic en;
        cmd_t cmd;
    } pipe_ctl_t;

endpackage
`default_nettype wire

// File: rtl/vau_prod_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vau_prod_lane: one component lane of the first pipeline stage
// Forms the two full-width products that the command needs for this
// component and the saturated add, subtract or negate result.
// ----------------------------------------------------------------------------
module vau_prod_lane #(
    parameter int WORD_W = 32
) (
    input  wire logic                       clk,
    input  wire vau_pkg::pipe_ctl_t         ctl,
    input  wire logic signed [WORD_W-1:0]   a_own,
    input  wire logic signed [WORD_W-1:0]   b_own,
    input  wire logic signed [WORD_W-1:0]   a_next,
    input  wire logic signed [WORD_W-1:0]   b_next,
    input  wire logic signed [WORD_W-1:0]   a_last,
    input  wire logic signed [WORD_W-1:0]   b_last,
    output logic signed [2*WORD_W-1:0]      prod0,
    output logic signed [2*WORD_W-1:0]      prod1,
    output logic signed [WORD_W-1:0]        simple,
    output logic                            simple_ov
);

    localparam int W1 = WORD_W + 1;
    localparam logic signed [WORD_W-1:0] W_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] W_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    logic signed [WORD_W-1:0]   m0a;
    logic signed [WORD_W-1:0]   m0b;
    logic signed [W1-1:0]       ext_a;
    logic signed [W1-1:0]       ext_b;
    logic signed [W1-1:0]       wide;
    logic signed [2*WORD_W-1:0] prod0_next;
    logic signed [2*WORD_W-1:0] prod1_next;
    logic signed [WORD_W-1:0]   simple_next;
    logic                       simple_ov_next;
    logic signed [2*WORD_W-1:0] prod0_reg;
    logic signed [2*WORD_W-1:0] prod1_reg;
    logic signed [WORD_W-1:0]   simple_reg;
    logic                       simple_ov_reg;

    always_comb
    begin
        m0a = a_own;
        m0b = b_own;
        unique case (ctl.cmd) inside
            vau_pkg::CMD_CROSS:
            begin
                m0a = a_next;
                m0b = b_last;
            end
            vau_pkg::CMD_SQLEN, vau_pkg::CMD_LEN, vau_pkg::CMD_NORM:
            begin
                m0b = a_own;
            end
            default:
            begin
            end
        endcase
    end

    assign prod0_next = m0a * m0b;
    assign prod1_next = a_last * b_next;

    // The add, subtract and negate results need one extra bit; a mismatch of
    // the two top bits means the value left the word range.
    always_comb
    begin
        ext_a = W1'(a_own);
        ext_b = W1'(b_own);
        case (ctl.cmd)
            vau_pkg::CMD_ADD: wide = ext_a + ext_b;
            vau_pkg::CMD_SUB: wide = ext_a - ext_b;
            vau_pkg::CMD_NEG: wide = -ext_a;
            default:          wide = '0;
        endcase
        simple_ov_next = wide[WORD_W] ^ wide[WORD_W-1];
        if (simple_ov_next)
        begin
            simple_next = wide[WORD_W] ? W_MIN : W_MAX;
        end
        else
        begin
            simple_next = wide[WORD_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            prod0_reg     <= prod0_next;
            prod1_reg     <= prod1_next;
            simple_reg    <= simple_next;
            simple_ov_reg <= simple_ov_next;
        end
    end

    assign prod0     = prod0_reg;
    assign prod1     = prod1_reg;
    assign simple    = simple_reg;
    assign simple_ov = simple_ov_reg;

endmodule
`default_nettype wire

// File: rtl/vau_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vau_merge: merging stage of the three product lanes
// Scales and saturates the products into the multiply, cross, dot and
// squared length results, and forms the exact sum of squares.
// ----------------------------------------------------------------------------
module vau_merge #(
    parameter int WORD_W    = 32,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                       clk,
    input  wire vau_pkg::pipe_ctl_t         ctl,
    input  wire logic signed [2*WORD_W-1:0] prod0 [3],
    input  wire logic signed [2*WORD_W-1:0] prod1 [3],
    input  wire logic signed [WORD_W-1:0]   simple [3],
    input  wire logic [2:0]                 simple_ov,
    output logic signed [WORD_W-1:0]        vec [3],
    output logic signed [WORD_W-1:0]        scalar,
    output logic                            ovf,
    output logic [2*WORD_W-1:0]             sum_sq
);

    localparam int SW = 2 * WORD_W + 2;
    localparam logic signed [WORD_W-1:0] W_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] W_MIN = {1'b1, {(WORD_W-1){1'b0}}};
    localparam logic signed [SW-1:0]     S_MAX = SW'(W_MAX);
    localparam logic signed [SW-1:0]     S_MIN = SW'(W_MIN);

    // Returns the overflow flag above the saturated word.
    function automatic logic [WORD_W:0] sat_w(input logic signed [SW-1:0] v);
        logic [WORD_W:0] r;
        if (v > S_MAX)
        begin
            r = {1'b1, W_MAX};
        end
        else if (v < S_MIN)
        begin
            r = {1'b1, W_MIN};
        end
        else
        begin
            r = {1'b0, v[WORD_W-1:0]};
        end
        return r;
    endfunction

    logic signed [SW-1:0]     dot_sum;
    logic [WORD_W:0]          mul_sat [3];
    logic [WORD_W:0]          crs_sat [3];
    logic [WORD_W:0]          dot_sat;
    logic [WORD_W:0]          sql_sat;
    logic [2*WORD_W-1:0]      sum_sq_next;
    logic signed [WORD_W-1:0] vec_next [3];
    logic signed [WORD_W-1:0] scalar_next;
    logic                     ovf_next;
    logic signed [WORD_W-1:0] vec_reg [3];
    logic signed [WORD_W-1:0] scalar_reg;
    logic                     ovf_reg;
    logic [2*WORD_W-1:0]      sum_sq_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mul_sat[i] = sat_w(SW'(prod0[i]) >>> FRAC_BITS);
            crs_sat[i] = sat_w((SW'(prod0[i]) - SW'(prod1[i])) >>> FRAC_BITS);
        end
        dot_sum     = SW'(prod0[0]) + SW'(prod0[1]) + SW'(prod0[2]);
        dot_sat     = sat_w(dot_sum >>> FRAC_BITS);
        sum_sq_next = $unsigned(prod0[0]) + $unsigned(prod0[1]) + $unsigned(prod0[2]);
        sql_sat     = sat_w(signed'(SW'(sum_sq_next >> FRAC_BITS)));
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            vec_next[i] = '0;
        end
        scalar_next = '0;
        ovf_next    = 1'b0;
        unique case (ctl.cmd) inside
            vau_pkg::CMD_ADD, vau_pkg::CMD_SUB, vau_pkg::CMD_NEG:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    vec_next[i] = simple[i];
                end
                ovf_next = |simple_ov;
            end
            vau_pkg::CMD_MUL:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    vec_next[i] = mul_sat[i][WORD_W-1:0];
                end
                ovf_next = mul_sat[0][WORD_W] | mul_sat[1][WORD_W] | mul_sat[2][WORD_W];
            end
            vau_pkg::CMD_CROSS:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    vec_next[i] = crs_sat[i][WORD_W-1:0];
                end
                ovf_next = crs_sat[0][WORD_W] | crs_sat[1][WORD_W] | crs_sat[2][WORD_W];
            end
            vau_pkg::CMD_DOT:
            begin
                scalar_next = dot_sat[WORD_W-1:0];
                ovf_next    = dot_sat[WORD_W];
            end
            vau_pkg::CMD_SQLEN:
            begin
                scalar_next = sql_sat[WORD_W-1:0];
                ovf_next    = sql_sat[WORD_W];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            vec_reg    <= vec_next;
            scalar_reg <= scalar_next;
            ovf_reg    <= ovf_next;
            sum_sq_reg <= sum_sq_next;
        end
    end

    assign vec    = vec_reg;
    assign scalar = scalar_reg;
    assign ovf    = ovf_reg;
    assign sum_sq = sum_sq_reg;

endmodule
`default_nettype wire

// File: rtl/vau_sqrt_pipe.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vau_sqrt_pipe: pipelined integer square root
// Produces floor(sqrt(radicand)) with one root bit settled in each of
// WORD_W stages, keeping the exact remainder from stage to stage.
// ----------------------------------------------------------------------------
module vau_sqrt_pipe #(
    parameter int WORD_W = 32
) (
    input  wire logic                  clk,
    input  wire logic                  en,
    input  wire logic [2*WORD_W-1:0]   radicand,
    output logic [WORD_W-1:0]          root
);

    localparam int QW = 2 * WORD_W + 2;

    logic [QW-1:0]     rem_reg  [WORD_W];
    logic [WORD_W-1:0] root_reg [WORD_W];

    for (genvar t = 0; t < WORD_W; t++)
    begin : g_stage
        localparam int K = WORD_W - 1 - t;

        logic [QW-1:0]     rem_in;
        logic [WORD_W-1:0] root_in;
        logic [QW-1:0]     trial;
        logic              take;
        logic [QW-1:0]     rem_next;
        logic [WORD_W-1:0] root_next;

        if (t == 0)
        begin : g_first
            assign rem_in  = QW'(radicand);
            assign root_in = '0;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[t-1];
            assign root_in = root_reg[t-1];
        end

        // (r + 2^K)^2 - r^2, with r holding only bits above K.
        assign trial     = (QW'(root_in) << (K + 1)) | (QW'(1) << (2 * K));
        assign take      = (rem_in >= trial);
        assign rem_next  = take ? (rem_in - trial) : rem_in;
        assign root_next = take ? (root_in | (WORD_W'(1) << K)) : root_in;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[t]  <= rem_next;
                root_reg[t] <= root_next;
            end
        end
    end

    assign root = root_reg[WORD_W-1];

endmodule
`default_nettype wire

// File: rtl/vau_div_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vau_div_lane: pipelined fixed-point divider for one component
// Computes (num * 2^FRAC_BITS) / den truncated toward zero, by the vector
// length when normalizing, with saturation and zero divisor handling.
// ----------------------------------------------------------------------------
module vau_div_lane #(
    parameter int WORD_W    = 32,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic signed [WORD_W-1:0] num,
    input  wire logic signed [WORD_W-1:0] den,
    input  wire logic [WORD_W-1:0]        root,
    input  wire logic                     is_norm,
    output logic signed [WORD_W-1:0]      quot,
    output logic                          ovf,
    output logic                          dz
);

    localparam int NW = WORD_W + FRAC_BITS;
    localparam int DW = 2 * WORD_W + FRAC_BITS;
    localparam logic signed [WORD_W-1:0] W_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] W_MIN = {1'b1, {(WORD_W-1){1'b0}}};
    localparam logic [WORD_W-1:0]        HALF  = {1'b1, {(WORD_W-1){1'b0}}};

    typedef struct packed {
        logic neg;
        logic zero;
        logic big;
        logic nneg;
        logic nzero;
    } flags_t;

    logic [WORD_W-1:0] nmag;
    logic [WORD_W-1:0] dmag;
    logic [NW-1:0]     dividend;
    flags_t            flg_next;

    logic [DW-1:0]     rem_reg [WORD_W];
    logic [WORD_W-1:0] d_reg   [WORD_W];
    flags_t            flg_reg [WORD_W+1];
    logic [WORD_W-1:0] q_reg   [1:WORD_W];

    always_comb
    begin
        nmag = num[WORD_W-1] ? ($unsigned(~num) + 1'b1) : $unsigned(num);
        if (is_norm)
        begin
            dmag = root;
        end
        else
        begin
            dmag = den[WORD_W-1] ? ($unsigned(~den) + 1'b1) : $unsigned(den);
        end
        dividend       = NW'(nmag) << FRAC_BITS;
        flg_next.neg   = num[WORD_W-1] ^ (den[WORD_W-1] & ~is_norm);
        flg_next.zero  = (dmag == '0);
        // A quotient of 2^WORD_W or more saturates whatever its sign.
        flg_next.big   = ((dividend >> WORD_W) >= NW'(dmag));
        flg_next.nneg  = num[WORD_W-1];
        flg_next.nzero = (num == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= DW'(dividend);
            d_reg[0]   <= dmag;
            flg_reg[0] <= flg_next;
        end
    end

    for (genvar t = 0; t < WORD_W; t++)
    begin : g_iter
        localparam int K = WORD_W - 1 - t;

        logic [WORD_W-1:0] q_in;
        logic [DW-1:0]     shifted;
        logic              take;
        logic [WORD_W-1:0] q_next;

        if (t == 0)
        begin : g_first
            assign q_in = '0;
        end
        else
        begin : g_rest
            assign q_in = q_reg[t];
        end

        assign shifted = DW'(d_reg[t]) << K;
        assign take    = (rem_reg[t] >= shifted);
        assign q_next  = take ? (q_in | (WORD_W'(1) << K)) : q_in;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[t+1]   <= q_next;
                flg_reg[t+1] <= flg_reg[t];
            end
        end

        if (t < WORD_W - 1)
        begin : g_carry
            logic [DW-1:0] rem_next;

            assign rem_next = take ? (rem_reg[t] - shifted) : rem_reg[t];

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[t+1] <= rem_next;
                    d_reg[t+1]   <= d_reg[t];
                end
            end
        end
    end

    always_comb
    begin
        dz = 1'b0;
        ovf = 1'b0;
        if (flg_reg[WORD_W].zero)
        begin
            dz = 1'b1;
            if (flg_reg[WORD_W].nzero)
            begin
                quot = '0;
            end
            else
            begin
                quot = flg_reg[WORD_W].nneg ? W_MIN : W_MAX;
            end
        end
        else if (!flg_reg[WORD_W].neg)
        begin
            if (flg_reg[WORD_W].big || q_reg[WORD_W][WORD_W-1])
            begin
                quot = W_MAX;
                ovf  = 1'b1;
            end
            else
            begin
                quot = q_reg[WORD_W];
            end
        end
        else
        begin
            if (flg_reg[WORD_W].big || (q_reg[WORD_W] > HALF))
            begin
                quot = W_MIN;
                ovf  = 1'b1;
            end
            else
            begin
                quot = ~q_reg[WORD_W] + 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/vec3_arith_unit_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vec3_arith_unit_top: three-component fixed-point vector ALU
// Componentwise add, subtract, multiply, divide and negate, dot and cross
// product, squared length, length and normalize, with saturation flags.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while the response side does not stall; the
//   depth is set by the square root and divider pipelines, each settling one
//   result bit per stage.
// Reset: rst_n clears the stage valid bits and the output valid only; the
//   data registers are not reset.
// ----------------------------------------------------------------------------
module vec3_arith_unit_top #(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire logic [3:0]         command,
    input  wire logic signed [31:0] a_x,
    input  wire logic signed [31:0] a_y,
    input  wire logic signed [31:0] a_z,
    input  wire logic signed [31:0] b_x,
    input  wire logic signed [31:0] b_y,
    input  wire logic signed [31:0] b_z,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output logic signed [31:0]      res_x,
    output logic signed [31:0]      res_y,
    output logic signed [31:0]      res_z,
    output logic signed [31:0]      res_scalar,
    output logic                    overflow,
    output logic                    div_zero
);

    // Arithmetic is carried at W bits; operands are the low W bits of each
    // port and results are sign extended back to the 32-bit ports.
    localparam int W      = (WORD_BITS < 32) ? WORD_BITS : 32;
    // Stage numbering: 1 = product lanes, 2 = merge, SQ_END = last root
    // stage, SQ_END+1 = divider setup, L = last quotient stage.
    localparam int SQ_END = W + 2;
    localparam int L      = 2 * W + 3;
    localparam logic signed [W-1:0] W_MAX = {1'b0, {(W-1){1'b1}}};

    // The whole pipeline moves together. It freezes only when a finished
    // result waits in the output register and another one is ready behind
    // it, so bubbles are squeezed out while the consumer stalls.
    logic en;
    logic valid_reg [1:L];
    logic rsp_valid_reg;
    logic rsp_valid_next;

    vau_pkg::cmd_t          cmd_reg [1:L];
    logic signed [W-1:0]    a_reg   [1:SQ_END][3];
    logic signed [W-1:0]    b_reg   [1:SQ_END][3];

    logic signed [W-1:0]    op_a [3];
    logic signed [W-1:0]    op_b [3];
    vau_pkg::pipe_ctl_t     lane_ctl;
    vau_pkg::pipe_ctl_t     merge_ctl;

    logic signed [2*W-1:0]  prod0 [3];
    logic signed [2*W-1:0]  prod1 [3];
    logic signed [W-1:0]    simple [3];
    logic [2:0]             simple_ov;

    logic signed [W-1:0]    mrg_vec [3];
    logic signed [W-1:0]    mrg_scalar;
    logic                   mrg_ovf;
    logic [2*W-1:0]         sum_sq;

    logic [W-1:0]           root_w;
    logic                   is_norm;
    logic signed [W-1:0]    div_q [3];
    logic [2:0]             div_ov;
    logic [2:0]             div_dz;

    // Results of the short commands ride alongside the root and divider.
    logic signed [W-1:0]    fvec_reg [3:L][3];
    logic signed [W-1:0]    fsc_reg  [3:L];
    logic                   fov_reg  [3:L];
    logic [W-1:0]           root_reg [SQ_END+1:L];

    logic signed [W-1:0]    fin_vec [3];
    logic signed [W-1:0]    fin_sc;
    logic                   fin_ov;
    logic                   fin_dz;

    logic signed [W-1:0]    res_x_reg;
    logic signed [W-1:0]    res_y_reg;
    logic signed [W-1:0]    res_z_reg;
    logic signed [W-1:0]    res_sc_reg;
    logic                   ovf_reg;
    logic                   dz_reg;

    assign en        = !(rsp_valid_reg && rsp_stall && valid_reg[L]);
    assign req_stall = !en;

    assign op_a[0] = signed'(a_x[W-1:0]);
    assign op_a[1] = signed'(a_y[W-1:0]);
    assign op_a[2] = signed'(a_z[W-1:0]);
    assign op_b[0] = signed'(b_x[W-1:0]);
    assign op_b[1] = signed'(b_y[W-1:0]);
    assign op_b[2] = signed'(b_z[W-1:0]);

    assign lane_ctl.en   = en;
    assign lane_ctl.cmd  = vau_pkg::cmd_t'(command);
    assign merge_ctl.en  = en;
    assign merge_ctl.cmd = cmd_reg[1];

    // Lane i handles component i; for the cross product it multiplies the
    // two other components in both orders.
    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        vau_prod_lane #(
            .WORD_W    (W)
        ) u_lane (
            .clk       (clk),
            .ctl       (lane_ctl),
            .a_own     (op_a[i]),
            .b_own     (op_b[i]),
            .a_next    (op_a[(i + 1) % 3]),
            .b_next    (op_b[(i + 1) % 3]),
            .a_last    (op_a[(i + 2) % 3]),
            .b_last    (op_b[(i + 2) % 3]),
            .prod0     (prod0[i]),
            .prod1     (prod1[i]),
            .simple    (simple[i]),
            .simple_ov (simple_ov[i])
        );
    end

    vau_merge #(
        .WORD_W    (W),
        .FRAC_BITS (FRAC_BITS)
    ) u_merge (
        .clk       (clk),
        .ctl       (merge_ctl),
        .prod0     (prod0),
        .prod1     (prod1),
        .simple    (simple),
        .simple_ov (simple_ov),
        .vec       (mrg_vec),
        .scalar    (mrg_scalar),
        .ovf       (mrg_ovf),
        .sum_sq    (sum_sq)
    );

    // The root of the exact sum of squares serves both length and normalize.
    vau_sqrt_pipe #(
        .WORD_W (W)
    ) u_sqrt (
        .clk      (clk),
        .en       (en),
        .radicand (sum_sq),
        .root     (root_w)
    );

    assign is_norm = (cmd_reg[SQ_END] == vau_pkg::CMD_NORM);

    for (genvar i = 0; i < 3; i++)
    begin : g_div
        vau_div_lane #(
            .WORD_W    (W),
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .clk     (clk),
            .en      (en),
            .num     (a_reg[SQ_END][i]),
            .den     (b_reg[SQ_END][i]),
            .root    (root_w),
            .is_norm (is_norm),
            .quot    (div_q[i]),
            .ovf     (div_ov[i]),
            .dz      (div_dz[i])
        );
    end

    // Stage valid bits and the output valid are the only reset state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 1; s <= L; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                valid_reg[1] <= req_valid;
                for (int s = 2; s <= L; s++)
                begin
                    valid_reg[s] <= valid_reg[s-1];
                end
            end
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_comb
    begin
        if (en && valid_reg[L])
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    // Delay lines for the command, the operands, the short results and the
    // root, each aligned with the stage that consumes it.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmd_reg[1] <= vau_pkg::cmd_t'(command);
            for (int s = 2; s <= L; s++)
            begin
                cmd_reg[s] <= cmd_reg[s-1];
            end
            a_reg[1] <= op_a;
            b_reg[1] <= op_b;
            for (int s = 2; s <= SQ_END; s++)
            begin
                a_reg[s] <= a_reg[s-1];
                b_reg[s] <= b_reg[s-1];
            end
            fvec_reg[3] <= mrg_vec;
            fsc_reg[3]  <= mrg_scalar;
            fov_reg[3]  <= mrg_ovf;
            for (int s = 4; s <= L; s++)
            begin
                fvec_reg[s] <= fvec_reg[s-1];
                fsc_reg[s]  <= fsc_reg[s-1];
                fov_reg[s]  <= fov_reg[s-1];
            end
            root_reg[SQ_END+1] <= root_w;
            for (int s = SQ_END + 2; s <= L; s++)
            begin
                root_reg[s] <= root_reg[s-1];
            end
        end
    end

    // Final selection. Divide and normalize take the quotients, length takes
    // the saturated root, and every other command its short result. The
    // zero vector normalizes to the zero vector with the divide flag set.
    always_comb
    begin
        fin_vec = fvec_reg[L];
        fin_sc  = fsc_reg[L];
        fin_ov  = fov_reg[L];
        fin_dz  = 1'b0;
        unique case (cmd_reg[L])
            vau_pkg::CMD_DIV:
            begin
                fin_vec = div_q;
                fin_ov  = |div_ov;
                fin_dz  = |div_dz;
            end
            vau_pkg::CMD_NORM:
            begin
                if (root_reg[L] == '0)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        fin_vec[i] = '0;
                    end
                    fin_ov = 1'b0;
                    fin_dz = 1'b1;
                end
                else
                begin
                    fin_vec = div_q;
                    fin_ov  = |div_ov;
                end
            end
            vau_pkg::CMD_LEN:
            begin
                fin_ov = root_reg[L][W-1];
                fin_sc = root_reg[L][W-1] ? W_MAX : signed'(root_reg[L]);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en && valid_reg[L])
        begin
            res_x_reg  <= fin_vec[0];
            res_y_reg  <= fin_vec[1];
            res_z_reg  <= fin_vec[2];
            res_sc_reg <= fin_sc;
            ovf_reg    <= fin_ov;
            dz_reg     <= fin_dz;
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign res_x      = 32'(res_x_reg);
    assign res_y      = 32'(res_y_reg);
    assign res_z      = 32'(res_z_reg);
    assign res_scalar = 32'(res_sc_reg);
    assign overflow   = ovf_reg;
    assign div_zero   = dz_reg;

`ifndef SYNTHESIS
    // The request side is held off only by a stuck result with another
    // result ready behind it.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (rsp_valid && rsp_stall && valid_reg[L]))
        else $error("request stalled without a blocked result");

    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> valid_reg[1])
        else $error("accepted word did not enter the pipeline");

    a_norm_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (en && valid_reg[L] && (cmd_reg[L] == vau_pkg::CMD_NORM) && (root_reg[L] == '0))
        |=> (rsp_valid && div_zero && !overflow && (res_x == 0) && (res_y == 0)
             && (res_z == 0)))
        else $error("zero vector normalize did not give a zero result");

    a_len_vec: assert property (@(posedge clk) disable iff (!rst_n)
        (en && valid_reg[L] && (cmd_reg[L] == vau_pkg::CMD_LEN))
        |=> (rsp_valid && !div_zero && (res_x == 0) && (res_y == 0) && (res_z == 0)))
        else $error("length result carried a vector part");
`endif

endmodule
`default_nettype wire

// File: dv/tb_vec3_arith_unit_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_vec3_arith_unit_top: self-checking bench for the fixed-point vector ALU
// Drives request words through the valid/stall handshake with random gaps,
// predicts every response with exact wide arithmetic, and compares each
// response word field by field. The bench also throttles the response side,
// including one long hold-off that fills the pipeline.
// ----------------------------------------------------------------------------
module tb_vec3_arith_unit_top;

    localparam int FRAC = 16;
    localparam int WDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 150;

    typedef logic signed [31:0]  word_t;
    typedef logic signed [127:0] wide_t;

    // One response word as the block presents it.
    typedef struct {
        word_t x;
        word_t y;
        word_t z;
        word_t s;
        logic  ov;
        logic  dz;
    } vec_result_t;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    logic [3:0]  command;
    word_t       a_x, a_y, a_z, b_x, b_y, b_z;
    logic        rsp_valid;
    logic        rsp_stall;
    word_t       res_x, res_y, res_z, res_scalar;
    logic        overflow;
    logic        div_zero;

    // Set by the stimulus to ask the response side for one long hold-off.
    bit          hold_rsp;
    bit          timed_out;
    int          idle_cycles;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts the response of every accepted request word and
    // keeps the predictions in order until the matching response arrives.
    // ------------------------------------------------------------------------
    class vec_scoreboard;
        vec_result_t pending_results[$];
        int          mismatches;

        // Clamps an exact value to the 32-bit range, noting saturation.
        function word_t clamp_word(wide_t v, ref logic ov);
            if (v > wide_t'(32'sh7fffffff)) begin
                ov = 1'b1;
                return 32'sh7fffffff;
            end
            if (v < -wide_t'(64'sh80000000)) begin
                ov = 1'b1;
                return 32'sh80000000;
            end
            return word_t'(v);
        endfunction

        function wide_t int_sqrt(wide_t v);
            wide_t root;
            wide_t bitv;
            root = 0;
            bitv = wide_t'(1) <<< 66;
            while (bitv > v) bitv = bitv >>> 2;
            while (bitv != 0) begin
                if (v >= root + bitv) begin
                    v = v - (root + bitv);
                    root = (root >>> 1) + bitv;
                end else begin
                    root = root >>> 1;
                end
                bitv = bitv >>> 2;
            end
            return root;
        endfunction

        function vec_result_t compute_vec_result(logic [3:0] code, word_t a[3], word_t b[3]);
            vec_result_t res;
            wide_t wa[3];
            wide_t wb[3];
            wide_t r[3];
            wide_t sc;
            wide_t sumsq;
            wide_t len;
            logic ov;
            logic dz;
            for (int i = 0; i < 3; i++) begin
                wa[i] = a[i];
                wb[i] = b[i];
                r[i] = 0;
            end
            sc = 0;
            ov = 1'b0;
            dz = 1'b0;
            sumsq = wa[0] * wa[0] + wa[1] * wa[1] + wa[2] * wa[2];
            case (vau_pkg::cmd_t'(code))
                vau_pkg::CMD_ADD: for (int i = 0; i < 3; i++) r[i] = wa[i] + wb[i];
                vau_pkg::CMD_SUB: for (int i = 0; i < 3; i++) r[i] = wa[i] - wb[i];
                vau_pkg::CMD_MUL:
                    for (int i = 0; i < 3; i++) r[i] = (wa[i] * wb[i]) >>> FRAC;
                vau_pkg::CMD_DIV:
                    for (int i = 0; i < 3; i++) begin
                        if (wb[i] == 0) begin
                            dz = 1'b1;
                            r[i] = (wa[i] > 0) ? wide_t'(32'sh7fffffff) :
                                   (wa[i] < 0) ? -wide_t'(64'sh80000000) : 0;
                        end else begin
                            r[i] = (wa[i] <<< FRAC) / wb[i];
                        end
                    end
                vau_pkg::CMD_DOT:
                    sc = (wa[0] * wb[0] + wa[1] * wb[1] + wa[2] * wb[2]) >>> FRAC;
                vau_pkg::CMD_CROSS:
                begin
                    r[0] = (wa[1] * wb[2] - wa[2] * wb[1]) >>> FRAC;
                    r[1] = (wa[2] * wb[0] - wa[0] * wb[2]) >>> FRAC;
                    r[2] = (wa[0] * wb[1] - wa[1] * wb[0]) >>> FRAC;
                end
                vau_pkg::CMD_SQLEN: sc = sumsq >>> FRAC;
                vau_pkg::CMD_LEN: sc = int_sqrt(sumsq);
                vau_pkg::CMD_NORM:
                begin
                    len = int_sqrt(sumsq);
                    if (len == 0) dz = 1'b1;
                    else for (int i = 0; i < 3; i++) r[i] = (wa[i] <<< FRAC) / len;
                end
                vau_pkg::CMD_NEG: for (int i = 0; i < 3; i++) r[i] = -wa[i];
                default: ;
            endcase
            // Division by zero is not saturation, so the bounds pass unflagged.
            res.x = clamp_word(r[0], ov);
            res.y = clamp_word(r[1], ov);
            res.z = clamp_word(r[2], ov);
            res.s = clamp_word(sc, ov);
            res.ov = ov;
            res.dz = dz;
            return res;
        endfunction

        function void note_request(logic [3:0] code, word_t a[3], word_t b[3]);
            pending_results.push_back(compute_vec_result(code, a, b));
        endfunction

        task report_mismatch(string what, word_t got, word_t want);
            $display("%0t: MISMATCH %s got %h expected %h", $realtime, what, got, want);
            mismatches++;
        endtask

        task check_response(vec_result_t got);
            vec_result_t want;
            if (pending_results.size() == 0) begin
                report_mismatch("res_x with no request pending", got.x, '0);
                return;
            end
            want = pending_results.pop_front();
            if (got.x !== want.x) report_mismatch("res_x", got.x, want.x);
            if (got.y !== want.y) report_mismatch("res_y", got.y, want.y);
            if (got.z !== want.z) report_mismatch("res_z", got.z, want.z);
            if (got.s !== want.s) report_mismatch("res_scalar", got.s, want.s);
            if (got.ov !== want.ov) report_mismatch("overflow", word_t'(got.ov), word_t'(want.ov));
            if (got.dz !== want.dz) report_mismatch("div_zero", word_t'(got.dz), word_t'(want.dz));
        endtask
    endclass

    vec_scoreboard sb;

    vec3_arith_unit_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .command    (command),
        .a_x        (a_x),
        .a_y        (a_y),
        .a_z        (a_z),
        .b_x        (b_x),
        .b_y        (b_y),
        .b_z        (b_z),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .res_x      (res_x),
        .res_y      (res_y),
        .res_z      (res_z),
        .res_scalar (res_scalar),
        .overflow   (overflow),
        .div_zero   (div_zero)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Monitor: both channels are sampled at the clock edge, before any of the
    // edge's register updates land, so a handshake is seen exactly as the
    // block sees it.
    always @(posedge clk)
    begin
        vec_result_t got;
        word_t ra[3];
        word_t rb[3];
        if (rst_n && req_valid && !req_stall) begin
            ra = '{a_x, a_y, a_z};
            rb = '{b_x, b_y, b_z};
            sb.note_request(command, ra, rb);
        end
        if (rst_n && rsp_valid && !rsp_stall) begin
            got.x = res_x;
            got.y = res_y;
            got.z = res_z;
            got.s = res_scalar;
            got.ov = overflow;
            got.dz = div_zero;
            sb.check_response(got);
        end
    end

    // Watchdog: any stretch without a handshake on either side that is far
    // longer than the pipeline depth plus the longest hold-off means a hang.
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_LIMIT && !timed_out) begin
                timed_out = 1'b1;
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Mostly short gaps, some long ones, and runs with none at all.
    function int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 55) return 0;
        if (sel < 90) return $urandom_range(1, 3);
        if (sel < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Response side: random stall pattern, plus one long hold-off on request.
    initial
    begin
        int n;
        rsp_stall = 1'b0;
        @(posedge rst_n);
        forever begin
            if (hold_rsp) begin
                rsp_stall <= 1'b1;
                repeat (400) @(posedge clk);
                hold_rsp = 1'b0;
            end
            n = pick_gap();
            if (n > 0) begin
                rsp_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // Offers one request word and returns at the edge where it is accepted,
    // leaving valid high so a following word can go out back to back.
    task automatic send_word(logic [3:0] code, word_t a[3], word_t b[3]);
        req_valid <= 1'b1;
        command <= code;
        a_x <= a[0];
        a_y <= a[1];
        a_z <= a[2];
        b_x <= b[0];
        b_y <= b[1];
        b_z <= b[2];
        do @(posedge clk); while (!(req_valid && !req_stall));
    endtask

    // Inserts a gap after an accepted word, if one is drawn.
    task automatic idle_sender(int n);
        if (n > 0) begin
            req_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_results.size() != 0) @(posedge clk);
    endtask

    // Operand mix: extremes, zeros, small Q16.16 values and full-range bits.
    function word_t pick_operand();
        case ($urandom_range(0, 9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 0;
            3, 4: return word_t'($urandom_range(0, 32'h00100000)) - 32'sh00080000;
            5: return word_t'($urandom_range(0, 32'h04000000)) - 32'sh02000000;
            default: return word_t'($urandom);
        endcase
    endfunction

    function logic [3:0] pick_command();
        if ($urandom_range(0, 19) == 0) return 4'($urandom_range(10, 15));
        return 4'($urandom_range(int'(vau_pkg::CMD_ADD), int'(vau_pkg::CMD_NEG)));
    endfunction

    localparam word_t MAXW = 32'sh7fffffff;
    localparam word_t MINW = 32'sh80000000;
    localparam word_t ONE  = 32'sh00010000;

    initial
    begin
        word_t a[3];
        word_t b[3];
        logic [3:0] code;
        sb = new();
        hold_rsp = 1'b0;
        timed_out = 1'b0;
        idle_cycles = 0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        command = '0;
        {a_x, a_y, a_z, b_x, b_y, b_z} = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words: each command at the word extremes, division by a
        // zero component with positive, negative and zero dividends, the
        // zero vector for normalize, and unused command codes.
        for (int c = int'(vau_pkg::CMD_ADD); c <= int'(vau_pkg::CMD_NEG); c++) begin
            a = '{MAXW, MINW, ONE};
            b = '{MAXW, MAXW, MINW};
            send_word(4'(c), a, b);
        end
        a = '{ONE, -ONE, 0};
        b = '{0, 0, 0};
        send_word(vau_pkg::CMD_DIV, a, b);
        a = '{MAXW, MINW, 32'sh00030000};
        b = '{32'sh00000001, 32'shffffffff, 32'sh00020000};
        send_word(vau_pkg::CMD_DIV, a, b);
        a = '{0, 0, 0};
        send_word(vau_pkg::CMD_NORM, a, b);
        a = '{32'sh00000001, 0, 0};
        send_word(vau_pkg::CMD_NORM, a, b);
        a = '{MINW, MINW, MINW};
        send_word(vau_pkg::CMD_LEN, a, b);
        send_word(vau_pkg::CMD_SQLEN, a, b);
        send_word(vau_pkg::CMD_NEG, a, b);
        a = '{-ONE, 32'sh00018000, 32'shfffe8000};
        b = '{32'sh00028000, -ONE, 32'sh00000003};
        send_word(vau_pkg::CMD_MUL, a, b);
        send_word(vau_pkg::CMD_DOT, a, b);
        send_word(vau_pkg::CMD_CROSS, a, b);
        send_word(4'd10, a, b);
        send_word(4'd15, a, b);
        drain_results();

        // Random words. Early on the response side takes one long hold-off
        // while requests keep coming, so the pipeline fills and stalls its
        // input; halfway the sender waits for every pending response.
        for (int n = 0; n < 700; n++) begin
            if (n == 50) hold_rsp = 1'b1;
            if (n == 350) drain_results();
            code = pick_command();
            for (int i = 0; i < 3; i++) begin
                a[i] = pick_operand();
                b[i] = pick_operand();
            end
            if (code == vau_pkg::CMD_NORM && $urandom_range(0, 9) == 0) a = '{0, 0, 0};
            send_word(code, a, b);
            idle_sender(pick_gap());
        end
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
